// File: rtl/sqmrf_pkg.sv
// Shared types and constants for the square matrix rotate/flip block.
// No dependencies.
`default_nettype none

package sqmrf_pkg;

    localparam int DEFAULT_MAX_DIM = 8;
    localparam int VALUE_W         = 32;
    localparam int CFG_DATA_W      = 4;
    localparam int CFG_INDEX_W     = 2;
    localparam int DIM_REG_W       = 4;
    localparam int MODE_W          = 2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COLS = 2'd2;

    // transform codes
    localparam logic [MODE_W-1:0] MODE_CW   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CCW  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_VFLIP = 2'd2;
    localparam logic [MODE_W-1:0] MODE_HALF = 2'd3;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_EMIT
    } seq_state_t;

    typedef struct packed {
        logic busy;
        logic rd_en;
        logic rd_last;
    } seq_status_t;

endpackage

`default_nettype wire

// File: rtl/sqmrf_store.sv
// Element store: single write port, one registered read port.
// Depends on sqmrf_pkg.
`default_nettype none

module sqmrf_store #(
    parameter int MAX_DIM = sqmrf_pkg::DEFAULT_MAX_DIM,
    parameter int ADDR_W  = $clog2(MAX_DIM * MAX_DIM)
) (
    input  wire                                 clk,
    input  wire                                 wr_en,
    input  wire  [ADDR_W-1:0]                   wr_addr,
    input  wire  [sqmrf_pkg::VALUE_W-1:0]       wr_data,
    input  wire                                 rd_en,
    input  wire  [ADDR_W-1:0]                   rd_addr,
    output logic [sqmrf_pkg::VALUE_W-1:0]       rd_data
);
    import sqmrf_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/sqmrf_seq.sv
// Emit sequencer: walks the output matrix row-major and issues store reads.
// Depends on sqmrf_pkg.
`default_nettype none

module sqmrf_seq #(
    parameter int MAX_DIM = sqmrf_pkg::DEFAULT_MAX_DIM,
    parameter int ADDR_W  = $clog2(MAX_DIM * MAX_DIM),
    parameter int CNT_W   = $clog2(MAX_DIM + 1)
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              launch,
    input  wire  [CNT_W-1:0]                 n_in,
    input  wire  [CNT_W-1:0]                 m_in,
    input  wire  [sqmrf_pkg::MODE_W-1:0]     mode_in,
    output sqmrf_pkg::seq_status_t           status,
    output logic [ADDR_W-1:0]                rd_addr
);
    import sqmrf_pkg::*;

    localparam int IDX_W = $clog2(MAX_DIM);

    seq_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  r_reg, r_next;
    logic [IDX_W-1:0]  c_reg, c_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  m_reg, m_next;
    logic [MODE_W-1:0] mode_reg, mode_next;

    logic [IDX_W-1:0]  n_m1, m_m1;
    logic [IDX_W-1:0]  sr, sc;
    logic              at_last;
    logic [ADDR_W-1:0] sr_x, m_x;

    assign n_m1    = IDX_W'(n_reg - CNT_W'(1));
    assign m_m1    = IDX_W'(m_reg - CNT_W'(1));
    assign at_last = (r_reg == n_m1) && (c_reg == m_m1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE: if (launch) state_next = SEQ_EMIT;
            SEQ_EMIT: if (at_last) state_next = SEQ_IDLE;
            default:  state_next = SEQ_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        status.busy    = (state_reg == SEQ_EMIT);
        status.rd_en   = (state_reg == SEQ_EMIT);
        status.rd_last = (state_reg == SEQ_EMIT) && at_last;
    end

    // position counters and latched shape
    always_comb
    begin
        r_next    = r_reg;
        c_next    = c_reg;
        n_next    = n_reg;
        m_next    = m_reg;
        mode_next = mode_reg;
        if (state_reg == SEQ_IDLE)
        begin
            if (launch)
            begin
                r_next    = '0;
                c_next    = '0;
                n_next    = n_in;
                m_next    = m_in;
                mode_next = mode_in;
            end
        end
        else if (c_reg == m_m1)
        begin
            c_next = '0;
            r_next = r_reg + IDX_W'(1);
        end
        else
        begin
            c_next = c_reg + IDX_W'(1);
        end
    end

    // source coordinate for each transform
    always_comb
    begin
        unique case (mode_reg)
            MODE_CW:
            begin
                sr = n_m1 - c_reg;
                sc = r_reg;
            end
            MODE_CCW:
            begin
                sr = c_reg;
                sc = n_m1 - r_reg;
            end
            MODE_VFLIP:
            begin
                sr = n_m1 - r_reg;
                sc = c_reg;
            end
            default:
            begin
                sr = n_m1 - r_reg;
                sc = m_m1 - c_reg;
            end
        endcase
    end

    assign sr_x    = ADDR_W'(sr);
    assign m_x     = ADDR_W'(m_reg);
    assign rd_addr = sr_x * m_x + ADDR_W'(sc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        c_reg    <= c_next;
        n_reg    <= n_next;
        m_reg    <= m_next;
        mode_reg <= mode_next;
    end

endmodule

`default_nettype wire

// File: rtl/square_matrix_rotate_flip_core.sv
// Matrix rotate/flip core: load N*M elements, then stream the transformed matrix.
// The transfer that completes the matrix launches the emit pass; each read goes
// through the registered store port and the strobe register, and results follow
// one per cycle, total N*M of them. Loading takes one transfer per cycle while
// busy is low; busy is high through the emit pass (one store read per cycle).
// Reset: async active low; mode=0, rows=8, cols=8, load count zero. The
// element store is not reset. Results cannot be stalled by the receiver.
`default_nettype none

module square_matrix_rotate_flip_core #(
    parameter int MAX_DIM = sqmrf_pkg::DEFAULT_MAX_DIM
) (
    input  wire                                      clk,
    input  wire                                      rst_n,
    // configuration write port
    input  wire                                      cfg_we,
    input  wire  [sqmrf_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire  [sqmrf_pkg::CFG_DATA_W-1:0]         cfg_data,
    // element input
    input  wire                                      start,
    output logic                                     busy,
    input  wire  signed [sqmrf_pkg::VALUE_W-1:0]     elem_value,
    // result output
    output logic                                     out_valid,
    output logic signed [sqmrf_pkg::VALUE_W-1:0]     out_value,
    output logic                                     out_last
);
    import sqmrf_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam int LC_W   = $clog2(DEPTH + 1);

    // configuration registers
    logic [MODE_W-1:0]    mode_reg;
    logic [DIM_REG_W-1:0] rows_reg;
    logic [DIM_REG_W-1:0] cols_reg;

    // load side
    logic [LC_W-1:0]   load_count_reg, load_count_next;
    logic [LC_W-1:0]   count_inc;
    logic [LC_W-1:0]   total;
    logic [CNT_W-1:0]  n_dim, cols_dim, m_dim;
    logic              xfer;
    logic              complete;
    logic              wr_en;

    // emit side
    seq_status_t       seq_st;
    logic [ADDR_W-1:0] rd_addr;
    logic [VALUE_W-1:0] rd_data;
    logic              out_valid_reg;
    logic              out_last_reg;

    // Dimensions: zero reads as one, anything above MAX_DIM as MAX_DIM.
    function automatic logic [CNT_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
        logic [CNT_W-1:0] res;
        if (v == '0)
            res = CNT_W'(1);
        else if (32'(v) > MAX_DIM)
            res = CNT_W'(MAX_DIM);
        else
            res = CNT_W'(v);
        return res;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_CW;
            rows_reg <= DIM_REG_W'(8);
            cols_reg <= DIM_REG_W'(8);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE: mode_reg <= cfg_data[MODE_W-1:0];
                REG_ROWS: rows_reg <= cfg_data[DIM_REG_W-1:0];
                REG_COLS: cols_reg <= cfg_data[DIM_REG_W-1:0];
                default:  ;
            endcase
        end
    end

    // quarter turns are square: columns follow rows
    assign n_dim    = clamp_dim(rows_reg);
    assign cols_dim = clamp_dim(cols_reg);
    assign m_dim    = (mode_reg == MODE_CW || mode_reg == MODE_CCW) ? n_dim : cols_dim;
    assign total    = LC_W'(n_dim) * LC_W'(m_dim);

    assign xfer      = start && !busy;
    assign count_inc = load_count_reg + LC_W'(1);
    assign complete  = (count_inc >= total);
    // count never passes DEPTH-1 before a transfer; guard kept for safety
    assign wr_en     = xfer && (load_count_reg < LC_W'(DEPTH));

    always_comb
    begin
        load_count_next = load_count_reg;
        if (xfer)
        begin
            load_count_next = complete ? '0 : count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= '0;
        end
        else
        begin
            load_count_reg <= load_count_next;
        end
    end

    // Element k of a load lands at entry k; the emit pass turns the
    // transform into read addressing, so no data is moved inside the store.
    sqmrf_store #(
        .MAX_DIM (MAX_DIM),
        .ADDR_W  (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (load_count_reg[ADDR_W-1:0]),
        .wr_data (elem_value),
        .rd_en   (seq_st.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Launch on the completing transfer with the shape in force right now.
    sqmrf_seq #(
        .MAX_DIM (MAX_DIM),
        .ADDR_W  (ADDR_W),
        .CNT_W   (CNT_W)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .launch  (xfer && complete),
        .n_in    (n_dim),
        .m_in    (m_dim),
        .mode_in (mode_reg),
        .status  (seq_st),
        .rd_addr (rd_addr)
    );

    assign busy = seq_st.busy;

    // strobe and last flag are registered to line up with the store's registered read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= seq_st.rd_en;
            out_last_reg  <= seq_st.rd_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;
    assign out_value = rd_data;

    // no store write while the emit pass reads
    a_no_wr_during_rd: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !seq_st.rd_en)
        else $error("store write during emit read");

    // last flag only rides on a result transfer
    a_last_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_last |-> out_valid)
        else $error("out_last without out_valid");

    // the final read ends the emit pass
    a_last_read_ends: assert property (@(posedge clk) disable iff (!rst_n)
        seq_st.rd_last |=> !busy)
        else $error("busy after final read");

    // a completing transfer is followed by a read in the next cycle
    a_launch_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && complete) |=> seq_st.rd_en)
        else $error("emit pass did not start");

endmodule

`default_nettype wire

// File: tb/square_matrix_rotate_flip_core_tb.sv
// Testbench for square_matrix_rotate_flip_core: directed and random matrices through all
// four transforms, checked against an in-bench predictor. Needs rtl/sqmrf_pkg.sv and the core.
`timescale 1ns / 1ps

module square_matrix_rotate_flip_core_tb;

    import sqmrf_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int MAX_DIM     = DEFAULT_MAX_DIM;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int RAND_ITEMS  = 420;
    // Longest quiet stretch in a correct run is a sender gap plus a settle; nothing
    // moving for this long means the block has hung.
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 6;
    localparam int REPORT_MAX  = 10;

    // ------------------------------------------------------------------
    // DUT connections, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                           clk        = 1'b0;
    logic                           rst_n      = 1'b0;
    logic                           cfg_we     = 1'b0;
    logic [CFG_INDEX_W-1:0]         cfg_index  = '0;
    logic [CFG_DATA_W-1:0]          cfg_data   = '0;
    logic                           start      = 1'b0;
    logic                           busy;
    logic signed [VALUE_W-1:0]      elem_value = '0;
    logic                           out_valid;
    logic signed [VALUE_W-1:0]      out_value;
    logic                           out_last;

    square_matrix_rotate_flip_core #(
        .MAX_DIM (MAX_DIM)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .start      (start),
        .busy       (busy),
        .elem_value (elem_value),
        .out_valid  (out_valid),
        .out_value  (out_value),
        .out_last   (out_last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: shadow copy of the registers and the element store
    // ------------------------------------------------------------------
    logic [MODE_W-1:0]              cur_mode  = MODE_CW;
    logic [DIM_REG_W-1:0]           cur_rows  = 4'd8;
    logic [DIM_REG_W-1:0]           cur_cols  = 4'd8;
    logic [VALUE_W-1:0]             matrix_copy [STORE_DEPTH];
    int                             loaded    = 0;
    int                             matrices_out = 0;

    // transformed elements still owed by the block, oldest first
    logic signed [VALUE_W-1:0]      pending_value [$];
    logic                           pending_last  [$];

    int                             fail_count   = 0;
    int                             items_sent   = 0;
    int                             gap_max      = 15;
    int                             quiet_cycles = 0;

    // Out-of-range dimensions: zero acts as one, anything above MAX_DIM as MAX_DIM.
    function automatic int used_dim(logic [DIM_REG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    // Columns only matter for the flip and the half turn; quarter turns are square.
    function automatic int used_cols();
        if (cur_mode == MODE_CW || cur_mode == MODE_CCW)
            return used_dim(cur_rows);
        return used_dim(cur_cols);
    endfunction

    function automatic int matrix_size();
        return used_dim(cur_rows) * used_cols();
    endfunction

    // One accepted element: store it, and if the load now covers the matrix
    // size under the current registers, queue the whole transformed matrix.
    task automatic take_element(logic [VALUE_W-1:0] v);
        int n;
        int m;
        int total;
        int src_r;
        int src_c;
        int k;
        n     = used_dim(cur_rows);
        m     = used_cols();
        total = n * m;
        if (loaded < STORE_DEPTH)
            matrix_copy[loaded] = v;
        loaded = (loaded + 1) & 7'h7f;
        if (loaded < total)
            return;
        loaded = 0;
        matrices_out++;
        k = 0;
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < m; c++) begin
                case (cur_mode)
                    MODE_CW: begin
                        src_r = n - 1 - c;
                        src_c = r;
                    end
                    MODE_CCW: begin
                        src_r = c;
                        src_c = n - 1 - r;
                    end
                    MODE_VFLIP: begin
                        src_r = n - 1 - r;
                        src_c = c;
                    end
                    default: begin  // half turn
                        src_r = n - 1 - r;
                        src_c = m - 1 - c;
                    end
                endcase
                pending_value.push_back(matrix_copy[src_r * m + src_c]);
                k++;
                pending_last.push_back(k == total);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Write one register; the strobe is dropped after the edge that takes the write and stays low
    // across the next edge, so that back to back writes never raise and lower cfg_we in the same step.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_MODE: cur_mode = data[MODE_W-1:0];
            REG_ROWS: cur_rows = data;
            REG_COLS: cur_cols = data;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mode write carries random junk in the unused upper data bits.
    task automatic configure(logic [MODE_W-1:0] mode, logic [DIM_REG_W-1:0] rows,
                             logic [DIM_REG_W-1:0] cols);
        write_reg(REG_MODE, {2'($urandom_range(0, 3)), mode});
        write_reg(REG_ROWS, rows);
        write_reg(REG_COLS, cols);
    endtask

    // Send one element and wait for the transfer. start stays high when no gap
    // follows, so the next element goes out on the very next cycle unless busy holds it.
    task automatic send_element(logic signed [VALUE_W-1:0] v);
        int gap;
        start      <= 1'b1;
        elem_value <= v;
        do
            @(posedge clk);
        while (busy);
        take_element(v);
        items_sent++;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending, wait for every owed result, then let the pipeline drain.
    task automatic settle();
        start <= 1'b0;
        while (pending_value.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Mostly small sides; sometimes zero, the full side, or above the limit.
    function automatic logic [DIM_REG_W-1:0] rand_dim();
        case ($urandom_range(0, 9))
            0: return 4'($urandom_range(MAX_DIM + 1, 15));
            1: return 4'd0;
            2: return 4'(MAX_DIM);
            default: return 4'($urandom_range(1, 4));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // One small matrix per transform, with the value extremes in play.
    task automatic test_each_transform();
        configure(MODE_CW, 4'd2, 4'd5);
        send_element(32'h8000_0000);
        send_element(32'h7fff_ffff);
        send_element(32'h0000_0000);
        send_element(32'hffff_ffff);
        settle();
        configure(MODE_CCW, 4'd2, 4'd1);
        send_element(32'h5555_5555);
        send_element(32'haaaa_aaaa);
        send_element(32'h0000_0001);
        send_element(32'hffff_fffe);
        settle();
        configure(MODE_VFLIP, 4'd2, 4'd1);
        send_element(32'sd10);
        send_element(-32'sd10);
        settle();
        configure(MODE_HALF, 4'd1, 4'd3);
        send_element(32'sd1);
        send_element(32'sd2);
        send_element(32'sd3);
        settle();
    endtask

    // Zero sides act as one; oversized sides act as MAX_DIM.
    task automatic test_dim_limits();
        configure(MODE_CW, 4'd0, 4'd0);
        send_element(32'sd77);
        settle();
        configure(MODE_HALF, 4'd1, 4'd15);
        for (int i = 0; i < MAX_DIM; i++)
            send_element(rand_elem());
        settle();
    endtask

    // Shrink the matrix after more elements have arrived than the new size:
    // the next element completes it under the new registers.
    task automatic test_midload_resize();
        configure(MODE_VFLIP, 4'd2, 4'd2);
        send_element(32'sd100);
        send_element(32'sd200);
        send_element(32'sd300);
        settle();
        write_reg(REG_ROWS, 4'd1);
        send_element(32'sd400);
        settle();
    endtask

    // Random matrices with random transforms; about one in five is resized
    // part way through its load.
    task automatic test_random_matrices();
        int base;
        int total;
        int done_before;
        base = items_sent;
        while (items_sent - base < RAND_ITEMS) begin
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
            configure(2'($urandom_range(0, 3)), rand_dim(), rand_dim());
            total = matrix_size();
            if (total > 1 && $urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, total - 1))
                    send_element(rand_elem());
                settle();
                configure(2'($urandom_range(0, 3)), rand_dim(), rand_dim());
            end
            done_before = matrices_out;
            while (matrices_out == done_before)
                send_element(rand_elem());
            settle();
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking: the receiver never stalls, so every strobe is a transfer
    // ------------------------------------------------------------------
    task automatic note_mismatch(string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%s", msg);
    endtask

    always @(posedge clk) begin : result_check
        logic signed [VALUE_W-1:0] want_value;
        logic                      want_last;
        if (rst_n && out_valid) begin
            if (pending_value.size() == 0) begin
                note_mismatch($sformatf("unexpected result: value=%0d last=%0b",
                                        out_value, out_last));
            end
            else begin
                want_value = pending_value.pop_front();
                want_last  = pending_last.pop_front();
                if (out_value !== want_value)
                    note_mismatch($sformatf("out_value: expected %0d, got %0d",
                                            want_value, out_value));
                if (out_last !== want_last)
                    note_mismatch($sformatf("out_last: expected %0b, got %0b",
                                            want_last, out_last));
            end
        end
    end

    // Cycles with no transfer on any port.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((start && !busy) || out_valid || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin : run
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_each_transform();
        test_dim_limits();
        test_midload_resize();
        test_random_matrices();
        settle();
        if (fail_count == 0 && pending_value.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
